FILE: src/rwmv_pkg.sv
// Shared types and constants for the read window majority vote block.
package rwmv_pkg;

	// Default sizes, used as parameter defaults on the top level
	localparam int MAX_WINDOW_BASES_DEF = 4096;
	localparam int MAX_READ_LEN_DEF     = 1024;
	localparam int MAX_READS_DEF        = 64;

	localparam logic [12:0] WINDOW_LIMIT_RST = 13'd4096;

	// Command codes
	localparam logic [1:0] OP_BEGIN = 2'd0;
	localparam logic [1:0] OP_PUSH  = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_OVER_WIN = 2'd1;
	localparam logic [1:0] STAT_DROPPED  = 2'd2;
	localparam logic [1:0] STAT_TOO_LONG = 2'd3;

	// Base codes
	localparam logic [2:0] GAP_CODE = 3'd5;
	localparam logic [2:0] NO_VOTE  = 3'd5;
	localparam int         NUM_BASES = 5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DROP,
		ST_EVICT,
		ST_EVICT_WAIT,
		ST_QUERY,
		ST_PICK
	} state_t;

endpackage

FILE: src/read_window_majority_vote.sv
// Read window majority vote: sliding window of reads and per-position base vote.
//
// Command-style block. An item is taken at a rising edge with start high and
// busy low; its one result shows on status/voted_base/result_last for exactly
// one cycle with done high, and the receiver cannot stall it. A begin on a
// full read table passes through a drop state to drop the oldest read. A push
// that closes a read and pushes the window over its limit evicts the oldest
// reads one by one; each eviction after the first waits on a read of the
// read-entry memory. Any other begin or push shows done the cycle after the
// transfer, and busy stays low.
// A query streams the committed reads through the read-entry memory and the
// base memory at one read a cycle, then picks the vote; the read-entry memory
// has a single read port. The user must write window_limit through
// cfg_valid/cfg_ready only while the block is idle; the block itself does not
// enforce this. cfg_ready is always high. Both memories come up undefined
// and need no clearing pass: only entries of committed reads are ever used.
module read_window_majority_vote #(
	parameter int MAX_WINDOW_BASES = rwmv_pkg::MAX_WINDOW_BASES_DEF,
	parameter int MAX_READ_LEN     = rwmv_pkg::MAX_READ_LEN_DEF,
	parameter int MAX_READS        = rwmv_pkg::MAX_READS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [31:0] position,
	input  logic [2:0]  base_code,
	input  logic        last_item,
	output logic        done,
	output logic [1:0]  status,
	output logic [2:0]  voted_base,
	output logic        result_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [12:0] window_limit
);

	localparam int STORE_DEPTH = MAX_WINDOW_BASES + MAX_READ_LEN;
	localparam int SA_W   = $clog2(STORE_DEPTH);
	localparam int SLOT_W = $clog2(MAX_READS);
	localparam int CNT_W  = $clog2(MAX_READS + 1);
	localparam int LEN_W  = $clog2(MAX_READ_LEN + 1);
	localparam int TW0    = $clog2(2 * MAX_WINDOW_BASES + 1);
	localparam int TW1    = (TW0 > LEN_W) ? TW0 : LEN_W;
	localparam int CW     = (TW1 > 13) ? TW1 : 13;
	localparam int ENT_W  = 32 + SA_W + LEN_W;
	localparam int SUM_W  = CNT_W + 1;

	// Control and state registers
	rwmv_pkg::state_t state_q, state_d;
	logic [12:0]       limit_q;
	logic [SLOT_W-1:0] oldest_q;
	logic [CNT_W-1:0]  count_q;
	logic [CW-1:0]     total_q;
	logic [SA_W-1:0]   wp_q;
	logic [LEN_W-1:0]  cur_len_q;
	logic              open_q;
	logic [31:0]       open_start_q;
	logic [SA_W-1:0]   open_off_q;

	// Query pipeline
	logic [CNT_W-1:0]  k_q;
	logic [31:0]       pos_q;
	logic              v_s1, v_s2;
	logic [CNT_W-1:0]  cnt_q [rwmv_pkg::NUM_BASES];

	// Result registers
	logic              done_q;
	logic [1:0]        status_q;
	logic [2:0]        voted_q;
	logic              last_q;

	// Memories
	logic [ENT_W-1:0]  ent_mem [MAX_READS];
	logic [ENT_W-1:0]  ent_rd_q;
	logic [2:0]        base_mem [STORE_DEPTH];
	logic [2:0]        base_rd_q;

	logic              accept;
	logic [CW-1:0]     eff_limit;
	logic [SUM_W-1:0]  open_sum, q_sum;
	logic [SLOT_W-1:0] open_slot, q_slot, oldest_next, ent_raddr;
	logic [SA_W-1:0]   wp_inc;
	logic [LEN_W-1:0]  push_len;
	logic [CW-1:0]     commit_total;
	logic              push_ok, too_long, over_win, commit_ok, need_evict;
	logic [31:0]       e_start, diff;
	logic [SA_W-1:0]   e_off, b_addr;
	logic [LEN_W-1:0]  e_len;
	logic [CW-1:0]     total_after;
	logic [CNT_W-1:0]  count_after;
	logic              evict_more, hit, q_issue, q_empty;
	logic [SA_W:0]     b_sum;
	logic [2:0]        best;
	logic [CNT_W-1:0]  best_n;

	assign accept    = start && !busy;
	assign busy      = (state_q != rwmv_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;

	// Limits above the window size act as the window size
	assign eff_limit = (CW'(limit_q) > CW'(MAX_WINDOW_BASES)) ?
		CW'(MAX_WINDOW_BASES) : CW'(limit_q);

	// Ring arithmetic over the read table
	always_comb begin
		open_sum = SUM_W'(oldest_q) + SUM_W'(count_q);
		if (open_sum >= SUM_W'(MAX_READS))
			open_sum = open_sum - SUM_W'(MAX_READS);
		open_slot = SLOT_W'(open_sum);
		q_sum = SUM_W'(oldest_q) + SUM_W'(k_q);
		if (q_sum >= SUM_W'(MAX_READS))
			q_sum = q_sum - SUM_W'(MAX_READS);
		q_slot = SLOT_W'(q_sum);
		oldest_next = (oldest_q == SLOT_W'(MAX_READS - 1)) ? '0 : oldest_q + 1'b1;
	end

	assign wp_inc = (wp_q == SA_W'(STORE_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign push_len = cur_len_q + 1'b1;
	assign commit_total = total_q + CW'(push_len);

	// Push decode
	assign push_ok    = accept && (opcode == rwmv_pkg::OP_PUSH) && open_q;
	assign too_long   = (cur_len_q >= LEN_W'(MAX_READ_LEN));
	assign over_win   = (CW'(push_len) > eff_limit);
	assign commit_ok  = push_ok && !too_long && last_item && !over_win;
	assign need_evict = (commit_total > eff_limit) && (count_q != '0);

	// Entry fields from the read-entry memory
	assign e_start = ent_rd_q[ENT_W-1 -: 32];
	assign e_off   = ent_rd_q[LEN_W +: SA_W];
	assign e_len   = ent_rd_q[LEN_W-1:0];

	assign total_after = total_q - CW'(e_len);
	assign count_after = count_q - 1'b1;
	assign evict_more  = (total_after > eff_limit) && (count_after > CNT_W'(1));

	// Query stage 1: coverage test and base address
	assign diff  = pos_q - e_start;
	assign hit   = (pos_q >= e_start) && (diff < 32'(e_len));
	always_comb begin
		b_sum = (SA_W + 1)'(e_off) + (SA_W + 1)'(diff[SA_W:0]);
		if (b_sum >= (SA_W + 1)'(STORE_DEPTH))
			b_sum = b_sum - (SA_W + 1)'(STORE_DEPTH);
		b_addr = SA_W'(b_sum);
	end

	assign q_issue = (k_q < count_q);
	assign q_empty = !q_issue && !v_s1 && !v_s2;
	assign ent_raddr = (state_q == rwmv_pkg::ST_QUERY) ? q_slot : oldest_q;

	// Vote pick: ties go to the smaller code
	always_comb begin
		best   = rwmv_pkg::NO_VOTE;
		best_n = '0;
		for (int c = 0; c < rwmv_pkg::NUM_BASES; c++) begin
			if (cnt_q[c] > best_n) begin
				best_n = cnt_q[c];
				best   = 3'(c);
			end
		end
	end

	// Memories
	always_ff @(posedge clk) begin
		if (commit_ok)
			ent_mem[open_slot] <= {open_start_q, open_off_q, push_len};
		ent_rd_q <= ent_mem[ent_raddr];
	end

	always_ff @(posedge clk) begin
		if (push_ok && !too_long)
			base_mem[wp_q] <= (base_code > rwmv_pkg::GAP_CODE) ? rwmv_pkg::GAP_CODE : base_code;
		base_rd_q <= base_mem[b_addr];
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			rwmv_pkg::ST_IDLE: begin
				if (accept) begin
					if (opcode == rwmv_pkg::OP_BEGIN && count_q == CNT_W'(MAX_READS))
						state_d = rwmv_pkg::ST_DROP;
					else if (commit_ok && need_evict)
						state_d = rwmv_pkg::ST_EVICT;
					else if (opcode == rwmv_pkg::OP_QUERY)
						state_d = rwmv_pkg::ST_QUERY;
				end
			end
			rwmv_pkg::ST_DROP:       state_d = rwmv_pkg::ST_IDLE;
			rwmv_pkg::ST_EVICT:      state_d = evict_more ? rwmv_pkg::ST_EVICT_WAIT :
				rwmv_pkg::ST_IDLE;
			rwmv_pkg::ST_EVICT_WAIT: state_d = rwmv_pkg::ST_EVICT;
			rwmv_pkg::ST_QUERY:      if (q_empty) state_d = rwmv_pkg::ST_PICK;
			rwmv_pkg::ST_PICK:       state_d = rwmv_pkg::ST_IDLE;
			default:                 state_d = rwmv_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= rwmv_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			limit_q <= rwmv_pkg::WINDOW_LIMIT_RST;
		else if (cfg_valid && cfg_ready)
			limit_q <= window_limit;
	end

	// Datapath and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oldest_q   <= '0;
			count_q    <= '0;
			total_q    <= '0;
			wp_q       <= '0;
			cur_len_q  <= '0;
			open_q     <= 1'b0;
			open_off_q <= '0;
			k_q        <= '0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				rwmv_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (opcode)
							rwmv_pkg::OP_BEGIN: begin
								// an open read is thrown away silently
								if (open_q)
									wp_q <= open_off_q;
								open_off_q <= open_q ? open_off_q : wp_q;
								cur_len_q  <= '0;
								open_q     <= 1'b1;
								if (count_q != CNT_W'(MAX_READS))
									done_q <= 1'b1;
							end
							rwmv_pkg::OP_PUSH: begin
								if (!open_q) begin
									done_q <= 1'b1;
								end else if (too_long) begin
									wp_q      <= open_off_q;
									cur_len_q <= '0;
									open_q    <= 1'b0;
									done_q    <= 1'b1;
								end else if (!last_item) begin
									wp_q      <= wp_inc;
									cur_len_q <= push_len;
									done_q    <= 1'b1;
								end else if (over_win) begin
									wp_q      <= open_off_q;
									cur_len_q <= '0;
									open_q    <= 1'b0;
									done_q    <= 1'b1;
								end else begin
									wp_q      <= wp_inc;
									cur_len_q <= '0;
									open_q    <= 1'b0;
									count_q   <= count_q + 1'b1;
									total_q   <= commit_total;
									if (!need_evict)
										done_q <= 1'b1;
								end
							end
							rwmv_pkg::OP_QUERY: begin
								k_q  <= '0;
								v_s1 <= 1'b0;
								v_s2 <= 1'b0;
							end
							default: done_q <= 1'b1;
						endcase
					end
				end
				rwmv_pkg::ST_DROP: begin
					total_q  <= total_after;
					oldest_q <= oldest_next;
					count_q  <= count_after;
					done_q   <= 1'b1;
				end
				rwmv_pkg::ST_EVICT: begin
					total_q  <= total_after;
					oldest_q <= oldest_next;
					count_q  <= count_after;
					if (!evict_more)
						done_q <= 1'b1;
				end
				rwmv_pkg::ST_EVICT_WAIT: begin
				end
				rwmv_pkg::ST_QUERY: begin
					v_s1 <= q_issue;
					if (q_issue)
						k_q <= k_q + 1'b1;
					v_s2 <= v_s1 && hit;
				end
				rwmv_pkg::ST_PICK: done_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	// Payload registers: open read, query and result
	always_ff @(posedge clk) begin
		if (accept && opcode == rwmv_pkg::OP_BEGIN)
			open_start_q <= position;
		if (accept) begin
			last_q  <= last_item;
			voted_q <= rwmv_pkg::NO_VOTE;
			pos_q   <= position;
			if (opcode == rwmv_pkg::OP_BEGIN && count_q == CNT_W'(MAX_READS))
				status_q <= rwmv_pkg::STAT_DROPPED;
			else if (push_ok && too_long)
				status_q <= rwmv_pkg::STAT_TOO_LONG;
			else if (push_ok && last_item && over_win)
				status_q <= rwmv_pkg::STAT_OVER_WIN;
			else
				status_q <= rwmv_pkg::STAT_OK;
			if (opcode == rwmv_pkg::OP_QUERY)
				for (int c = 0; c < rwmv_pkg::NUM_BASES; c++)
					cnt_q[c] <= '0;
		end
		// stage 2: base data back, count the vote
		if (state_q == rwmv_pkg::ST_QUERY && v_s2 && base_rd_q < rwmv_pkg::GAP_CODE)
			cnt_q[base_rd_q] <= cnt_q[base_rd_q] + 1'b1;
		if (state_q == rwmv_pkg::ST_PICK)
			voted_q <= best;
	end

	assign done        = done_q;
	assign status      = status_q;
	assign voted_base  = voted_q;
	assign result_last = last_q;

endmodule

FILE: dv/read_window_majority_vote_tb.sv
// Self-checking testbench for the read window majority vote block.
module read_window_majority_vote_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = rwmv_pkg::MAX_WINDOW_BASES_DEF + rwmv_pkg::MAX_READ_LEN_DEF;
	localparam int N_READS     = rwmv_pkg::MAX_READS_DEF;
	localparam int STALL_LIMIT = 20000;

	// expected result of one command
	typedef struct packed {
		logic [1:0] status;
		logic [2:0] voted_base;
		logic       result_last;
	} vote_result_t;

	// directed command with an optional hand-written answer
	typedef struct {
		logic [1:0]  op;
		logic [31:0] pos;
		logic [2:0]  base;
		logic        last;
		bit          typed;
		logic [1:0]  st;
		logic [2:0]  vb;
	} cmd_row_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [31:0] position;
	logic [2:0]  base_code;
	logic        last_item;
	logic        done;
	logic [1:0]  status;
	logic [2:0]  voted_base;
	logic        result_last;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [12:0] window_limit;

	read_window_majority_vote dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .position(position), .base_code(base_code),
		.last_item(last_item), .done(done), .status(status),
		.voted_base(voted_base), .result_last(result_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_limit(window_limit)
	);

	// Shadow copy of the window state
	logic [2:0]  base_mem [STORE_DEPTH];
	logic [31:0] rd_start [N_READS];
	int          rd_off   [N_READS];
	int          rd_len   [N_READS];
	int          oldest, n_reads, total, wr_ptr, cur_len, lim_reg;
	bit          rd_open;

	vote_result_t expected_q[$];
	int  errors;
	int  idle_pct;
	int  stall_cnt;
	bit  accepted;

	int          idle_plan [4] = '{0, 83, 0, 33};
	logic [12:0] limits    [6] = '{13'd8191, 13'd1, 13'd40, 13'd300, 13'd4096, 13'd0};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int eff_limit();
		return (lim_reg > rwmv_pkg::MAX_WINDOW_BASES_DEF) ?
			rwmv_pkg::MAX_WINDOW_BASES_DEF : lim_reg;
	endfunction

	function automatic int open_idx();
		return (oldest + n_reads) % N_READS;
	endfunction

	function automatic void drop_oldest();
		if (n_reads != 0) begin
			total   -= rd_len[oldest];
			oldest   = (oldest + 1) % N_READS;
			n_reads--;
		end
	endfunction

	function automatic void discard_open();
		wr_ptr  = rd_off[open_idx()];
		cur_len = 0;
		rd_open = 0;
	endfunction

	// close the open read; over-limit reads are thrown away, then evict oldest
	function automatic logic [1:0] close_read();
		int s;
		s = open_idx();
		if (cur_len > eff_limit()) begin
			discard_open();
			return rwmv_pkg::STAT_OVER_WIN;
		end
		rd_len[s] = cur_len;
		n_reads++;
		total  += cur_len;
		cur_len = 0;
		rd_open = 0;
		while (total > eff_limit() && n_reads > 1)
			drop_oldest();
		return rwmv_pkg::STAT_OK;
	endfunction

	function automatic logic [2:0] majority_at(logic [31:0] pos);
		int          tally [rwmv_pkg::NUM_BASES];
		int          s, best_n;
		logic [31:0] d;
		logic [2:0]  b, best;
		best   = rwmv_pkg::NO_VOTE;
		best_n = 0;
		for (int c = 0; c < rwmv_pkg::NUM_BASES; c++)
			tally[c] = 0;
		for (int k = 0; k < n_reads; k++) begin
			s = (oldest + k) % N_READS;
			d = pos - rd_start[s];
			if (pos >= rd_start[s] && d < rd_len[s]) begin
				b = base_mem[(rd_off[s] + int'(d)) % STORE_DEPTH];
				if (b < rwmv_pkg::GAP_CODE)
					tally[b]++;
			end
		end
		for (int c = 0; c < rwmv_pkg::NUM_BASES; c++)
			if (tally[c] > best_n) begin
				best_n = tally[c];
				best   = c[2:0];
			end
		return best;
	endfunction

	function automatic vote_result_t window_step(logic [1:0] op, logic [31:0] pos,
			logic [2:0] base, logic last);
		vote_result_t r;
		int s;
		r = '{status: rwmv_pkg::STAT_OK, voted_base: rwmv_pkg::NO_VOTE, result_last: last};
		case (op)
			rwmv_pkg::OP_BEGIN: begin
				if (rd_open)
					discard_open();
				if (n_reads >= N_READS) begin
					drop_oldest();
					r.status = rwmv_pkg::STAT_DROPPED;
				end
				s = open_idx();
				rd_start[s] = pos;
				rd_off[s]   = wr_ptr;
				rd_len[s]   = 0;
				cur_len     = 0;
				rd_open     = 1;
			end
			rwmv_pkg::OP_PUSH: begin
				if (rd_open) begin
					if (cur_len >= rwmv_pkg::MAX_READ_LEN_DEF) begin
						discard_open();
						r.status = rwmv_pkg::STAT_TOO_LONG;
					end else begin
						base_mem[wr_ptr % STORE_DEPTH] =
							(base > rwmv_pkg::GAP_CODE) ? rwmv_pkg::GAP_CODE : base;
						wr_ptr = (wr_ptr + 1) % STORE_DEPTH;
						cur_len++;
						if (last)
							r.status = close_read();
					end
				end
			end
			rwmv_pkg::OP_QUERY: r.voted_base = majority_at(pos);
			default: ;
		endcase
		return r;
	endfunction

	// Present one command, hold it until the transfer, log the prediction.
	// busy is sampled at the falling edge so the decision is race free.
	task automatic issue(logic [1:0] op, logic [31:0] pos, logic [2:0] base,
			logic last, bit typed = 0, logic [1:0] st = rwmv_pkg::STAT_OK,
			logic [2:0] vb = rwmv_pkg::NO_VOTE);
		vote_result_t r;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		start     <= 1'b1;
		opcode    <= op;
		position  <= pos;
		base_code <= base;
		last_item <= last;
		forever begin
			@(negedge clk);
			if (!busy)
				break;
			@(posedge clk);
		end
		r = window_step(op, pos, base, last);
		if (typed)
			r = '{status: st, voted_base: vb, result_last: last};
		expected_q = {expected_q, r};
		accepted = 1;
		@(posedge clk);
	endtask

	// Register write only with the pipe drained and the block settled
	task automatic set_limit(logic [12:0] v);
		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (150) @(posedge clk);
		cfg_valid    <= 1'b1;
		window_limit <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		lim_reg = v;
	endtask

	// one read of n bases; close = 0 leaves it open
	task automatic load_read(logic [31:0] pos, int n, bit close);
		issue(rwmv_pkg::OP_BEGIN, pos, 3'($urandom_range(7)), 1'($urandom_range(1)));
		for (int i = 0; i < n; i++)
			issue(rwmv_pkg::OP_PUSH, $urandom, 3'($urandom_range(7)), close && (i == n - 1));
	endtask

	task automatic random_traffic(int n_items, logic [31:0] region, int span);
		int          issued, r, len;
		logic [31:0] p;
		issued = 0;
		while (issued < n_items) begin
			r = $urandom_range(99);
			p = region + $urandom_range(span);
			if (r < 65) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
				load_read(p, len, $urandom_range(9) != 0);
				issued += len + 1;
				repeat ($urandom_range(2)) begin
					issue(rwmv_pkg::OP_QUERY, region + $urandom_range(span + 12),
						3'($urandom_range(7)), 1'($urandom_range(1)));
					issued++;
				end
			end else if (r < 85) begin
				issue(rwmv_pkg::OP_QUERY, p, 3'($urandom_range(7)), 1'($urandom_range(1)));
				issued++;
			end else begin
				issue(2'($urandom_range(3)), $urandom, 3'($urandom_range(7)),
					1'($urandom_range(1)));
				issued++;
			end
		end
	endtask

	// Result checker: done is sampled at the falling edge of its cycle
	always @(negedge clk) begin
		vote_result_t e;
		if (arst_n && done) begin
			accepted = 1;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result status=%0d voted_base=%0d last=%0d",
					$realtime, status, voted_base, result_last);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
					errors++;
				end
				if (voted_base !== e.voted_base) begin
					$display("%0t: voted_base expected %0d actual %0d",
						$realtime, e.voted_base, voted_base);
					errors++;
				end
				if (result_last !== e.result_last) begin
					$display("%0t: result_last expected %0d actual %0d",
						$realtime, e.result_last, result_last);
					errors++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer or result means a hang.
	// Config pauses are far below the limit.
	always @(posedge clk) begin
		if (accepted)
			stall_cnt <= 0;
		else if (arst_n)
			stall_cnt <= stall_cnt + 1;
		accepted = 0;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("FAIL read_window_majority_vote");
			$finish;
		end
	end

	cmd_row_t directed [] = '{
		// query on an empty window: no votes
		'{rwmv_pkg::OP_QUERY, 32'h0, 3'd0, 1'b1, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		// push with no open read is ignored
		'{rwmv_pkg::OP_PUSH, 32'hFFFF_FFFF, 3'd4, 1'b1, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		// unused opcode does nothing
		'{2'd3, 32'hFFFF_FFFF, 3'd7, 1'b1, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		// read at the top of the address range, base code 7 becomes a gap
		'{rwmv_pkg::OP_BEGIN, 32'hFFFF_FFFF, 3'd7, 1'b1, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd7, 1'b1, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'hFFFF_FFFF, 3'd0, 1'b0, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		// single read of base code 4 at position 0
		'{rwmv_pkg::OP_BEGIN, 32'h0, 3'd0, 1'b0, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd4, 1'b1, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'h0, 3'd0, 1'b1, 1, rwmv_pkg::STAT_OK, 3'd4},
		// second read A,C,G over 0..2; tie at 0 goes to A
		'{rwmv_pkg::OP_BEGIN, 32'h0, 3'd0, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd0, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd1, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd2, 1'b1, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'h0, 3'd0, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'h2, 3'd0, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'h3, 3'd0, 1'b0, 1, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		// open read does not vote; a begin over it discards it
		'{rwmv_pkg::OP_BEGIN, 32'h1, 3'd0, 1'b1, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd3, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'h1, 3'd0, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_BEGIN, 32'h1, 3'd0, 1'b0, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_PUSH, 32'h0, 3'd6, 1'b1, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE},
		'{rwmv_pkg::OP_QUERY, 32'h1, 3'd5, 1'b1, 0, rwmv_pkg::STAT_OK, rwmv_pkg::NO_VOTE}
	};

	initial begin
		logic [31:0] region;
		arst_n       = 1'b0;
		start        = 1'b0;
		opcode       = rwmv_pkg::OP_QUERY;
		position     = '0;
		base_code    = '0;
		last_item    = 1'b0;
		cfg_valid    = 1'b0;
		window_limit = rwmv_pkg::WINDOW_LIMIT_RST;
		errors       = 0;
		idle_pct     = 0;
		stall_cnt    = 0;
		accepted     = 0;
		oldest = 0; n_reads = 0; total = 0; wr_ptr = 0; cur_len = 0; rd_open = 0;
		lim_reg = rwmv_pkg::WINDOW_LIMIT_RST;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			issue(directed[i].op, directed[i].pos, directed[i].base, directed[i].last,
				directed[i].typed, directed[i].st, directed[i].vb);

		// maximum register value (acts as the window size): overflow the read
		// table with short reads
		set_limit(13'd8191);
		for (int i = 0; i < N_READS + 3; i++)
			load_read(32'h200 + i, 1, 1);
		issue(rwmv_pkg::OP_QUERY, 32'h210, 3'd0, 1'b0);

		// minimum limit: two-base read is rejected, single base kept
		set_limit(13'd1);
		load_read(32'h300, 2, 1);
		load_read(32'h300, 1, 1);
		issue(rwmv_pkg::OP_QUERY, 32'h300, 3'd0, 1'b1);

		for (int ph = 0; ph < 6; ph++) begin
			set_limit((limits[ph] == 0) ? 13'($urandom_range(1, 8191)) : limits[ph]);
			idle_pct = idle_plan[ph % 4];
			region   = ($urandom_range(3) == 0) ? 32'($urandom) : 32'($urandom_range(200));
			random_traffic(90, region, 40);
		end

		start <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("PASS read_window_majority_vote");
		else
			$display("FAIL read_window_majority_vote");
		$finish;
	end

endmodule

FILE: read_window_majority_vote.f
src/rwmv_pkg.sv
src/read_window_majority_vote.sv
dv/read_window_majority_vote_tb.sv
